/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers on the block clock and reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general form with explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication on clk_i / rst_ni
`define ASSERT_IMP(label, ante, cons, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, (ante) |-> (cons), msg)

// next-cycle implication on clk_i / rst_ni
`define ASSERT_NXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, (ante) |=> (cons), msg)

`endif

/* hdl/fmrc_pkg.sv */
// ----------------------------------------------------------------------------
// fmrc_pkg
// shared types, constants and helpers of the first-move row run compressor
// ----------------------------------------------------------------------------
package fmrc_pkg;

  localparam int MAX_RECTS  = 8;
  localparam int NODE_BITS  = 20;
  localparam int COORD_BITS = 16;

  localparam int RANK_W  = 20;
  localparam int MASK_W  = 16;
  localparam int MOVE_W  = 4;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int RCNT_IN_W = 4;
  localparam int CADDR_W = 3;
  localparam int CFG_W0  = (NODE_BITS > RANK_W) ? NODE_BITS : RANK_W;
  localparam int CFG_W   = (CFG_W0 > COORD_BITS) ? CFG_W0 : COORD_BITS;

  localparam int RIDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RCNT_W = $clog2(MAX_RECTS + 1);

  localparam logic [MASK_W-1:0] MASK_SOURCE = 16'h7FFF;
  localparam logic [MASK_W-1:0] MASK_ALL    = 16'hFFFF;
  localparam logic [MASK_W-1:0] MASK_EMPTY  = 16'h8000;

  typedef enum logic [CADDR_W-1:0] {
    REG_SOURCE_INDEX = 3'd0,
    REG_SOURCE_RANK  = 3'd1,
    REG_SOURCE_X     = 3'd2,
    REG_SOURCE_Y     = 3'd3,
    REG_MODE         = 3'd4,
    REG_KEEP_DIVISOR = 3'd5,
    REG_DIST_THRESH  = 3'd6,
    REG_RECT_COUNT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] north;
    logic [COORD_BITS-1:0] south;
    logic [COORD_BITS-1:0] west;
    logic [COORD_BITS-1:0] east;
  } rect_entry_t;

  typedef struct packed {
    logic busy;
    logic flag;
  } unit_stat_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] run_start;
    logic [MOVE_W-1:0]    first_move;
    logic                 last_of_row;
  } out_word_t;

  function automatic logic [MOVE_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [MOVE_W-1:0] r;
    r = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = MOVE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/fmrc_div.sv */
// ----------------------------------------------------------------------------
// fmrc_div
// restoring remainder unit, one dividend bit per cycle, flags a zero remainder
// ----------------------------------------------------------------------------
module fmrc_div import fmrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NODE_BITS-1:0] dividend_i,
  input  logic [NODE_BITS-1:0] divisor_i,
  output unit_stat_t           stat_o
);

  localparam int CNT_W = $clog2(NODE_BITS + 1);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [NODE_BITS-1:0] dvd_q;
  logic [NODE_BITS-1:0] rem_q;
  logic [NODE_BITS:0]   trial;
  logic [NODE_BITS:0]   diff;

  assign trial = {rem_q, dvd_q[NODE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NODE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NODE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_q <= diff[NODE_BITS-1:0];
      end else begin
        rem_q <= trial[NODE_BITS-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.flag = (rem_q == '0);

endmodule

/* hdl/fmrc_rect.sv */
// ----------------------------------------------------------------------------
// fmrc_rect
// rectangle table and scanner, one entry compared per cycle
// ----------------------------------------------------------------------------
module fmrc_rect import fmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [SLOT_W-1:0]     wr_slot_i,
  input  rect_entry_t           wr_entry_i,
  input  logic                  start_i,
  input  logic [RCNT_IN_W-1:0]  count_i,
  input  logic [COORD_BITS-1:0] src_x_i,
  input  logic [COORD_BITS-1:0] src_y_i,
  input  logic [COORD_BITS-1:0] tgt_x_i,
  input  logic [COORD_BITS-1:0] tgt_y_i,
  output unit_stat_t            stat_o
);

  rect_entry_t          mem_q [MAX_RECTS];
  rect_entry_t          rd_q;
  logic                 rd_vld_q;
  logic                 busy_q;
  logic                 hit_q;
  logic [RCNT_W-1:0]    idx_q;
  logic [RCNT_W-1:0]    lim_q;
  logic [RCNT_W-1:0]    lim;
  logic                 issue;
  logic                 match;
  logic [COORD_BITS:0]  y_lo, y_hi, x_lo, x_hi;

  assign lim   = (32'(count_i) > MAX_RECTS) ? RCNT_W'(MAX_RECTS) : RCNT_W'(count_i);
  assign issue = busy_q && (idx_q < lim_q);

  // target inside: sy - n <= y <= sy + s and sx - w <= x <= sx + e
  assign y_lo  = {1'b0, tgt_y_i} + {1'b0, rd_q.north};
  assign y_hi  = {1'b0, src_y_i} + {1'b0, rd_q.south};
  assign x_lo  = {1'b0, tgt_x_i} + {1'b0, rd_q.west};
  assign x_hi  = {1'b0, src_x_i} + {1'b0, rd_q.east};
  assign match = (y_lo >= {1'b0, src_y_i}) && ({1'b0, tgt_y_i} <= y_hi) &&
                 (x_lo >= {1'b0, src_x_i}) && ({1'b0, tgt_x_i} <= x_hi);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_slot_i) < MAX_RECTS)) begin
      mem_q[wr_slot_i[RIDX_W-1:0]] <= wr_entry_i;
    end
    if (issue) begin
      rd_q <= mem_q[idx_q[RIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
      lim_q    <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
      lim_q    <= lim;
    end else if (busy_q) begin
      rd_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + RCNT_W'(1);
      end
      if (rd_vld_q && match) begin
        hit_q <= 1'b1;
      end
      if (!issue && !rd_vld_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.flag = hit_q;

endmodule

/* hdl/first_move_row_run_compressor.sv */
// a target word holds ready low until it is merged, so no new word is taken meanwhile:
// the remainder unit walks one index bit per cycle, the WORK state waits until both
// units are done, EVAL forms the mask and MERGE merges it into the run
// the merge waits until the two-word result queue is empty; a load word is taken in idle and stays there
// reset clears configuration, run state and the result queue; the rectangle
// table is left as is and is written by load words only
// ----------------------------------------------------------------------------
// first_move_row_run_compressor
// run-length compression of one first-move row with rectangle and rank rules
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_move_row_run_compressor import fmrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CADDR_W-1:0]    cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [SLOT_W-1:0]     rect_slot_i,
  input  logic [COORD_BITS-1:0] rect_north_i,
  input  logic [COORD_BITS-1:0] rect_south_i,
  input  logic [COORD_BITS-1:0] rect_west_i,
  input  logic [COORD_BITS-1:0] rect_east_i,
  input  logic [NODE_BITS-1:0]  target_index_i,
  input  logic [MASK_W-1:0]     move_mask_i,
  input  logic [RANK_W-1:0]     target_rank_i,
  input  logic [COORD_BITS-1:0] target_x_i,
  input  logic [COORD_BITS-1:0] target_y_i,
  input  logic                  row_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NODE_BITS-1:0]  run_start_o,
  output logic [MOVE_W-1:0]     first_move_o,
  output logic                  last_of_row_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_EVAL,
    ST_MERGE
  } state_e;

  state_e                state_q, state_d;

  logic [NODE_BITS-1:0]  src_idx_q;
  logic [RANK_W-1:0]     src_rank_q;
  logic [COORD_BITS-1:0] src_x_q, src_y_q;
  logic [MODE_W-1:0]     mode_q;
  logic [NODE_BITS-1:0]  divisor_q;
  logic [NODE_BITS-1:0]  thresh_q;
  logic [RCNT_IN_W-1:0]  rcount_q;

  logic [NODE_BITS-1:0]  t_q;
  logic [MASK_W-1:0]     mm_q;
  logic [RANK_W-1:0]     rank_q;
  logic [COORD_BITS-1:0] tx_q, ty_q;
  logic                  row_end_q;
  logic [MASK_W-1:0]     eff_q;

  logic [NODE_BITS-1:0]  run_begin_q;
  logic [MASK_W-1:0]     run_mask_q;
  logic                  run_open_q;

  out_word_t             slot0_q, slot1_q;
  logic                  v0_q, v1_q;

  logic                  accept, pop, can_merge;
  logic                  load_word, target_word;
  unit_stat_t            div_stat, rect_stat;
  rect_entry_t           wr_entry;

  logic [NODE_BITS-1:0]  idx_gap;
  logic                  mult, keep;
  logic [MASK_W-1:0]     own, eff;

  logic [MASK_W-1:0]     both;
  logic                  emit_a, emit_b;
  out_word_t             word_a, word_b;
  logic [NODE_BITS-1:0]  nb;
  logic [MASK_W-1:0]     nm;

  logic                  merge_go, units_idle;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_word   = accept && !op_i;
  assign target_word = accept && op_i;
  assign pop         = v0_q && out_ready_i;
  assign can_merge   = !v0_q && !v1_q;
  assign merge_go    = (state_q == ST_MERGE) && can_merge;
  assign units_idle  = !div_stat.busy && !rect_stat.busy;

  assign wr_entry.north = rect_north_i;
  assign wr_entry.south = rect_south_i;
  assign wr_entry.west  = rect_west_i;
  assign wr_entry.east  = rect_east_i;

  fmrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (target_word),
    .dividend_i (target_index_i),
    .divisor_i  (divisor_q),
    .stat_o     (div_stat)
  );

  fmrc_rect u_rect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (load_word),
    .wr_slot_i  (rect_slot_i),
    .wr_entry_i (wr_entry),
    .start_i    (target_word),
    .count_i    (rcount_q),
    .src_x_i    (src_x_q),
    .src_y_i    (src_y_q),
    .tgt_x_i    (tx_q),
    .tgt_y_i    (ty_q),
    .stat_o     (rect_stat)
  );

  // effective mask of the held target
  assign idx_gap = (t_q >= src_idx_q) ? (t_q - src_idx_q) : (src_idx_q - t_q);
  assign mult    = div_stat.flag;
  assign keep    = (mode_q[1] && (idx_gap > thresh_q) && mult) || (mode_q[0] && mult);
  assign own     = (mm_q == '0) ? MASK_EMPTY : mm_q;

  always_comb begin
    if (t_q == src_idx_q) begin
      eff = MASK_SOURCE;
    end else if (rect_stat.flag) begin
      eff = MASK_ALL;
    end else if (src_rank_q < rank_q) begin
      eff = keep ? own : MASK_ALL;
    end else begin
      eff = own;
    end
  end

  // run merge
  assign both = run_mask_q & eff_q;

  always_comb begin
    emit_a = 1'b0;
    nb     = run_begin_q;
    nm     = run_mask_q;
    if (!run_open_q) begin
      nb = t_q;
      nm = eff_q;
    end else if (both == '0) begin
      emit_a = 1'b1;
      nb     = t_q;
      nm     = eff_q;
    end else begin
      nm = both;
    end
    emit_b             = row_end_q;
    word_a.run_start   = run_begin_q;
    word_a.first_move  = lowest_bit(run_mask_q);
    word_a.last_of_row = 1'b0;
    word_b.run_start   = nb;
    word_b.first_move  = lowest_bit(nm);
    word_b.last_of_row = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (target_word) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!div_stat.busy && !rect_stat.busy) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (can_merge) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_idx_q   <= '0;
      src_rank_q  <= '0;
      src_x_q     <= '0;
      src_y_q     <= '0;
      mode_q      <= '0;
      divisor_q   <= NODE_BITS'(1);
      thresh_q    <= '0;
      rcount_q    <= '0;
      run_begin_q <= '0;
      run_mask_q  <= '0;
      run_open_q  <= 1'b0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_SOURCE_INDEX: src_idx_q  <= cfg_data_i[NODE_BITS-1:0];
          REG_SOURCE_RANK:  src_rank_q <= cfg_data_i[RANK_W-1:0];
          REG_SOURCE_X:     src_x_q    <= cfg_data_i[COORD_BITS-1:0];
          REG_SOURCE_Y:     src_y_q    <= cfg_data_i[COORD_BITS-1:0];
          REG_MODE:         mode_q     <= cfg_data_i[MODE_W-1:0];
          REG_KEEP_DIVISOR: divisor_q  <= cfg_data_i[NODE_BITS-1:0];
          REG_DIST_THRESH:  thresh_q   <= cfg_data_i[NODE_BITS-1:0];
          REG_RECT_COUNT:   rcount_q   <= cfg_data_i[RCNT_IN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_MERGE && can_merge) begin
        run_begin_q <= nb;
        run_mask_q  <= nm;
        run_open_q  <= !row_end_q;
        v0_q        <= emit_a || emit_b;
        v1_q        <= emit_a && emit_b;
      end else if (pop) begin
        v0_q <= v1_q;
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (target_word) begin
      t_q       <= target_index_i;
      mm_q      <= move_mask_i;
      rank_q    <= target_rank_i;
      tx_q      <= target_x_i;
      ty_q      <= target_y_i;
      row_end_q <= row_end_i;
    end
    if (state_q == ST_EVAL) begin
      eff_q <= eff;
    end
    if (state_q == ST_MERGE && can_merge) begin
      slot0_q <= emit_a ? word_a : word_b;
      slot1_q <= word_b;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign out_valid_o   = v0_q;
  assign run_start_o   = slot0_q.run_start;
  assign first_move_o  = slot0_q.first_move;
  assign last_of_row_o = slot0_q.last_of_row;

  `ASSERT_IMP(a_queue_order, v1_q, v0_q, "second queue word without a head word")
  `ASSERT_IMP(a_units_quiet, state_q == ST_IDLE, units_idle, "unit busy while idle")
  `ASSERT_NXT(a_row_close, merge_go && row_end_q, !run_open_q && v0_q, "row end did not flush")
  `ASSERT_IMP(a_eval_ready, state_q == ST_EVAL, units_idle, "mask formed before units finished")

endmodule
